// ----- rtl/core/mit_pkg.sv -----
// Package for the multiplexed interval timers: request kinds, FSM states,
// per-cell command struct and fixed constants. No dependencies.
`default_nettype none
package mit_pkg;
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_INSTALL = 3'd1;
    localparam logic [2:0] KIND_UNINST  = 3'd2;
    localparam logic [2:0] KIND_ENABLE  = 3'd3;
    localparam logic [2:0] KIND_DISABLE = 3'd4;

    localparam logic [15:0] STOP_MARK    = 16'hFFFF;
    localparam logic [15:0] MIN_DELAY    = 16'd5;
    localparam logic [15:0] MAX_DELAY    = 16'hFFFE;
    localparam logic [10:0] INTERVAL_CAP = 11'd1024;
    localparam int          DIV_STEPS    = 16;
    localparam int          CNT_W        = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_ARM,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic write;
        logic uninst;
        logic set_act;
        logic clr_act;
        logic tick;
        logic start;
        logic step;
        logic arm;
    } t_cell_op;
endpackage
`default_nettype wire

// ----- rtl/core/multiplexed_interval_timers.sv -----
// Top level of the multiplexed interval timers: command FSM, base-rate
// register, output register and a chain of mit_cell. Depends on mit_pkg.
//
//  channel | dir | tuser      | tdata (lowest bit first)
//  s_axis  | in  | kind[2:0]  | slot[2:0], delay[18:3], zero pad to 24
//  m_axis  | out | -          | fire_mask[7:0], hw_interval[18:8],
//          |     |            | timer_running[19], zero pad to 24
//
// Tick, enable, disable: idle, then the output state. Uninstall: a walk
// of the running minimum down the cell chain. Install: the 16-step serial
// divider runs for the new slot, then the walk. If a walk finds a new
// base rate that is not the stop mark, the divider runs once more in every
// cell in parallel. Reset is synchronous, active low, and leaves every
// slot uninstalled with the timer stopped. One request is in work at a
// time; the finished result waits in the output register.
`default_nettype none
module multiplexed_interval_timers #(
    parameter int SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // slot, delay, pad
    input  wire logic [2:0]  s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata   // fire_mask, hw_interval, timer_running, pad
);
    import mit_pkg::*;

    t_state      r_state, n_state;
    logic [2:0]  r_kind;
    logic [2:0]  r_slot;
    logic        r_all;      // second divide pass: every installed slot
    logic        r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0] r_base;
    logic [SLOTS-1:0] r_fire;
    logic        r_ovalid;
    logic [23:0] r_odata;

    t_cell_op    w_op;
    logic        w_accept;
    logic [2:0]  w_kind, w_slot;
    logic [15:0] w_din, w_delay;
    logic        w_ok;
    logic [SLOTS-1:0] w_sel, w_fire;
    logic [15:0] w_min [SLOTS+1];
    logic [10:0] w_div;
    logic        w_out_free;
    logic [10:0] w_hw;
    logic [7:0]  w_mask;

    assign w_kind   = s_axis_tuser;
    assign w_slot   = s_axis_tdata[2:0];
    assign w_din    = s_axis_tdata[18:3];
    assign w_ok     = int'(w_slot) < SLOTS;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;

    // clamp the requested delay into 5..65534
    assign w_delay = (w_din < MIN_DELAY) ? MIN_DELAY :
                     (w_din == STOP_MARK) ? MAX_DELAY : w_din;

    assign w_div = (r_base < 16'(INTERVAL_CAP)) ? r_base[10:0] : INTERVAL_CAP;

    // slot select: the addressed slot, or all slots on the re-arm pass
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (r_state == ST_IDLE) w_sel[i] = w_ok && (int'(w_slot) == i);
            else                    w_sel[i] = r_all || (int'(r_slot) == i);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_ok && w_kind == KIND_INSTALL)     n_state = ST_START;
                    else if (w_ok && w_kind == KIND_UNINST) n_state = ST_SCAN;
                    else                                    n_state = ST_OUT;
                end
            end
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = ST_ARM;
            ST_ARM:   n_state = r_phase ? ST_OUT : ST_SCAN;
            ST_SCAN: begin
                if (r_cnt == CNT_W'(SLOTS)) begin
                    if (w_min[SLOTS] != r_base && w_min[SLOTS] != STOP_MARK)
                        n_state = ST_START;
                    else
                        n_state = ST_OUT;
                end
            end
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // cell commands
    always_comb begin
        w_op = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_op.write   = w_accept && w_kind == KIND_INSTALL;
                w_op.uninst  = w_accept && w_kind == KIND_UNINST;
                w_op.set_act = w_accept && w_kind == KIND_ENABLE;
                w_op.clr_act = w_accept && w_kind == KIND_DISABLE;
                w_op.tick    = w_accept && w_kind == KIND_TICK;
            end
            ST_START: w_op.start = 1'b1;
            ST_DIV:   w_op.step  = 1'b1;
            ST_ARM:   w_op.arm   = 1'b1;
            default:  w_op = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_base   <= STOP_MARK;
            r_all    <= 1'b0;
            r_phase  <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_kind   <= KIND_TICK;
            r_slot   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready)              r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_all   <= 1'b0;
                    r_phase <= 1'b0;
                    r_cnt   <= '0;
                    if (w_accept) begin
                        r_kind <= w_kind;
                        r_slot <= w_slot;
                    end
                end
                ST_DIV:  r_cnt <= r_cnt + CNT_W'(1);
                ST_ARM:  r_cnt <= '0;
                ST_SCAN: begin
                    if (r_cnt == CNT_W'(SLOTS)) begin
                        // end of walk: hold the new minimum; re-arm all if it changed and is not the stop mark
                        r_base  <= w_min[SLOTS];
                        r_all   <= 1'b1;
                        r_phase <= 1'b1;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_OUT: ;
                default: r_cnt <= '0;
            endcase
        end
    end

    // fire mask is captured on the tick and cleared by any other request
    always_ff @(posedge i_clk) begin
        if (w_accept) r_fire <= (w_kind == KIND_TICK) ? w_fire : '0;
    end

    assign w_hw = (r_base == STOP_MARK) ? 11'd0 : w_div;
    always_comb begin
        w_mask = '0;
        for (int i = 0; i < SLOTS && i < 8; i++) w_mask[i] = r_fire[i];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free)
            r_odata <= {4'd0, (r_base != STOP_MARK), w_hw, w_mask};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign w_min[0] = STOP_MARK;
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        mit_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_sel   (w_sel[g]),
            .i_div   (w_div),
            .i_delay (w_delay),
            .i_min   (w_min[g]),
            .o_min   (w_min[g+1]),
            .o_fire  (w_fire[g])
        );
    end

    logic w_unused;
    assign w_unused = ^{r_kind, s_axis_tdata[23:19]};
endmodule
`default_nettype wire

// ----- rtl/core/mit_cell.sv -----
// One timer slot: delay, count, period, flags, a serial divider and one
// stage of the running-minimum chain. Depends on mit_pkg.
`default_nettype none
module mit_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mit_pkg::t_cell_op i_op,
    input  wire logic             i_sel,
    input  wire logic [10:0]      i_div,
    input  wire logic [15:0]      i_delay,
    input  wire logic [15:0]      i_min,
    output logic      [15:0]      o_min,
    output logic                  o_fire
);
    import mit_pkg::*;

    logic        r_inst, r_act;
    logic [15:0] r_delay, r_count, r_period, r_q, r_min;
    logic [10:0] r_rem;
    logic [11:0] w_trial;
    logic        w_ge;
    logic [15:0] w_next;

    assign w_trial = {r_rem, r_q[15]};
    assign w_ge    = w_trial >= {1'b0, i_div};
    assign w_next  = r_count + 16'd1;
    assign o_fire  = r_inst && r_act && (w_next == r_period);
    assign o_min   = r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inst   <= 1'b0;
            r_act    <= 1'b0;
            r_delay  <= '0;
            r_count  <= '0;
            r_period <= '0;
            r_min    <= STOP_MARK;
        end else begin
            // pass the running minimum to the next cell
            r_min <= (r_inst && r_delay < i_min) ? r_delay : i_min;
            if (i_sel && i_op.write) begin
                r_delay <= i_delay;
                r_inst  <= 1'b1;
                r_act   <= 1'b0;
            end
            if (i_sel && i_op.uninst) begin
                r_inst <= 1'b0;
                r_act  <= 1'b0;
            end
            if (i_sel && i_op.set_act) r_act <= 1'b1;
            if (i_sel && i_op.clr_act) r_act <= 1'b0;
            if (i_op.tick && r_inst && r_act) begin
                r_count <= o_fire ? 16'd0 : w_next;
            end
            if (i_op.arm && i_sel && r_inst) begin
                r_period <= r_q;
                r_count  <= r_q - 16'd1;
            end
        end
    end

    // restoring divider: one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_op.start) begin
            r_q   <= r_delay;
            r_rem <= '0;
        end else if (i_op.step) begin
            r_rem <= w_ge ? 11'(w_trial - {1'b0, i_div}) : w_trial[10:0];
            r_q   <= {r_q[14:0], w_ge};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/mit_checker.sv -----
// Port-level checker for multiplexed_interval_timers, bound to the top.
// Depends on nothing else.
`default_nettype none
module mit_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one is in work");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[19] |-> m_axis_tdata[18:8] == 11'd0)
        else $error("interval nonzero while stopped");
    a_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[19] |->
            m_axis_tdata[18:8] >= 11'd5 && m_axis_tdata[18:8] <= 11'd1024)
        else $error("interval out of range while running");
endmodule

bind multiplexed_interval_timers mit_checker u_mit_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- verif/mit_checker.sv -----
// Checker for the multiplexed interval timers: watches both stream channels,
// keeps its own copy of the slot state and compares every response. Uses mit_pkg.
`timescale 1ns / 1ps
module mit_scoreboard (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // slot, delay, pad
    input  wire logic [2:0]  s_axis_tuser,   // kind
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,   // fire_mask, hw_interval, timer_running, pad
    output int               o_errors,
    output int               o_pending
);
    import mit_pkg::*;

    typedef struct packed {
        logic [7:0]  fire_mask;
        logic [10:0] hw_interval;
        logic        running;
    } t_status;

    logic [15:0] delay_q [8];
    logic [15:0] count_q [8];
    logic [15:0] period_q [8];
    logic        installed_q [8];
    logic        active_q [8];
    logic [15:0] base_q;
    t_status     status_fifo [$];

    assign o_pending = status_fifo.size();

    function automatic logic [15:0] hw_rate();
        return (base_q < 16'(INTERVAL_CAP)) ? base_q : 16'(INTERVAL_CAP);
    endfunction

    function automatic void rearm(int i);
        logic [15:0] div;
        div = hw_rate();
        period_q[i] = (div != 0) ? delay_q[i] / div : 16'd0;
        count_q[i]  = period_q[i] - 16'd1;
    endfunction

    function automatic void recompute_base();
        logic [15:0] best;
        best = STOP_MARK;
        for (int i = 0; i < 8; i++)
            if (installed_q[i] && delay_q[i] < best) best = delay_q[i];
        if (best == base_q) return;
        base_q = best;
        if (best == STOP_MARK) return;
        for (int i = 0; i < 8; i++)
            if (installed_q[i]) rearm(i);
    endfunction

    function automatic t_status apply_request(logic [2:0] kind, logic [2:0] slot,
                                              logic [15:0] dly);
        t_status r;
        logic [15:0] rate;
        r = '0;
        case (kind)
            KIND_TICK: begin
                for (int i = 0; i < 8; i++) begin
                    if (installed_q[i] && active_q[i]) begin
                        count_q[i] = count_q[i] + 16'd1;
                        if (count_q[i] == period_q[i]) begin
                            count_q[i] = '0;
                            r.fire_mask[i] = 1'b1;
                        end
                    end
                end
            end
            KIND_INSTALL: begin
                if (dly < MIN_DELAY) dly = MIN_DELAY;
                if (dly > MAX_DELAY) dly = MAX_DELAY;
                delay_q[slot] = dly;
                installed_q[slot] = 1'b1;
                active_q[slot] = 1'b0;
                rearm(slot);
                recompute_base();
            end
            KIND_UNINST: begin
                if (installed_q[slot]) begin
                    installed_q[slot] = 1'b0;
                    active_q[slot] = 1'b0;
                    recompute_base();
                end
            end
            KIND_ENABLE:  active_q[slot] = 1'b1;
            KIND_DISABLE: active_q[slot] = 1'b0;
            default: ;
        endcase
        if (base_q != STOP_MARK) begin
            rate = hw_rate();
            r.hw_interval = rate[10:0];
            r.running = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_status want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                delay_q[i] = '0; count_q[i] = '0; period_q[i] = '0;
                installed_q[i] = 1'b0; active_q[i] = 1'b0;
            end
            base_q = STOP_MARK;
            status_fifo.delete();
            o_errors = 0;
        end else begin
            // Check the response first: a request accepted on this edge cannot
            // have produced it yet.
            if (m_axis_tvalid && m_axis_tready) begin
                got.fire_mask   = m_axis_tdata[7:0];
                got.hw_interval = m_axis_tdata[18:8];
                got.running     = m_axis_tdata[19];
                if (status_fifo.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected response %h", m_axis_tdata);
                end else begin
                    want = status_fifo.pop_front();
                    if (got !== want || m_axis_tdata[23:20] !== 4'b0) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: exp mask %h intv %0d run %b, got %h",
                                     want.fire_mask, want.hw_interval, want.running,
                                     m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                status_fifo.push_back(apply_request(s_axis_tuser, s_axis_tdata[2:0],
                                                    s_axis_tdata[18:3]));
        end
    end
endmodule

// ----- verif/testbench.sv -----
// Top of the multiplexed interval timer testbench: clock, reset, request
// stimulus and response back-pressure. Depends on mit_pkg and mit_scoreboard.
`timescale 1ns / 1ps
module testbench;
    import mit_pkg::*;

    localparam int RANDOM_REQUESTS = 850;
    localparam int CYCLE_LIMIT     = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // slot, delay, pad
    logic [2:0]  s_axis_tuser = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // fire_mask, hw_interval, timer_running, pad
    int          errors, pending;
    int          cycles = 0;
    bit          hold_off = 1'b0;     // long receiver stall for back-pressure

    always #4 i_clk = ~i_clk;

    multiplexed_interval_timers dut (.*);

    mit_scoreboard checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        // Mostly no or short gaps, now and then a long one.
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Present one request and hold it until the handshake completes.
    task automatic send_request(logic [2:0] kind, logic [2:0] slot, logic [15:0] dly);
        int gap;
        gap = gap_len();
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b0, dly, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_delay();
        // Weight toward small delays so that slots actually fire; keep the
        // extremes and the cap boundary in play.
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 6));
            1: return 16'($urandom_range(1020, 1030));
            2: return 16'($urandom_range(0, 65535));
            3: return 16'($urandom_range(65530, 65535));
            default: return 16'($urandom_range(5, 60));
        endcase
    endfunction

    // Receiver: random stalls, and one long hold-off requested by stimulus.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
        end
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("multiplexed_interval_timers verification failed");
            $finish;
        end
    end

    // Long stretch with the receiver held off while requests keep coming.
    initial begin
        wait (i_rst_n);
        repeat (2000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        int k;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stopped-timer requests, clamps, cap boundary, every kind.
        send_request(KIND_TICK, 3'd0, 16'd0);
        send_request(KIND_UNINST, 3'd3, 16'd0);          // uninstall of empty slot
        send_request(KIND_ENABLE, 3'd6, 16'd0);          // enable before install
        send_request(KIND_INSTALL, 3'd0, 16'd0);         // raised to minimum
        send_request(KIND_INSTALL, 3'd7, 16'hFFFF);      // saturated below stop mark
        send_request(KIND_ENABLE, 3'd0, 16'd0);
        send_request(KIND_ENABLE, 3'd7, 16'hFFFF);
        send_request(KIND_TICK, 3'd7, 16'hFFFF);
        send_request(KIND_TICK, 3'd0, 16'd0);
        send_request(KIND_INSTALL, 3'd0, 16'd2048);      // reinstall: base rises, cap
        send_request(KIND_INSTALL, 3'd3, 16'd1024);
        send_request(KIND_ENABLE, 3'd3, 16'd0);
        send_request(KIND_TICK, 3'd0, 16'd0);
        send_request(KIND_TICK, 3'd0, 16'd0);
        send_request(KIND_DISABLE, 3'd3, 16'd0);
        send_request(3'd5, 3'd1, 16'hAAAA);              // reserved kinds do nothing
        send_request(3'd6, 3'd2, 16'h5555);
        send_request(3'd7, 3'd4, 16'd1);
        send_request(KIND_UNINST, 3'd0, 16'd0);
        send_request(KIND_UNINST, 3'd3, 16'd0);
        send_request(KIND_UNINST, 3'd7, 16'd0);          // last one: timer stops
        send_request(KIND_TICK, 3'd0, 16'd0);

        // Random: ticks dominate so that enabled slots fire and counts advance.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            k = $urandom_range(0, 99);
            if (k < 45)
                send_request(KIND_TICK, 3'($urandom), 16'($urandom));
            else if (k < 60)
                send_request(KIND_INSTALL, 3'($urandom), pick_delay());
            else if (k < 70)
                send_request(KIND_UNINST, 3'($urandom), 16'($urandom));
            else if (k < 88)
                send_request(KIND_ENABLE, 3'($urandom), 16'($urandom));
            else if (k < 96)
                send_request(KIND_DISABLE, 3'($urandom), 16'($urandom));
            else
                send_request(3'($urandom_range(5, 7)), 3'($urandom), 16'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("multiplexed_interval_timers verification clean");
        else
            $display("multiplexed_interval_timers verification failed");
        $finish;
    end
endmodule
